[rtl/core/usm_pkg.sv]
// Shared types, constants and helpers of the unsharp mask core.
package usm_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned ROW_W      = 14;
  localparam int unsigned COL_SUM_W  = 10;
  localparam int unsigned WIN_SUM_W  = 12;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MIN_DIM       = 3;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 12'd256;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd768;

  // Arithmetic of the sharpening datapath.
  localparam int unsigned DIFF_W   = 13;
  localparam int unsigned PROD_W   = 26;
  localparam int unsigned NUM_W    = 27;
  localparam int unsigned QX_W     = 20;
  localparam int unsigned RECIP_SH = 23;
  localparam logic [QX_W-1:0]  RECIP     = 20'd932068;  // ceil(2^23 / 9)
  localparam logic [NUM_W-1:0] ONE_Q     = 27'd2304;    // 9 * 256
  localparam logic [NUM_W-1:0] ROUND_OFS = 27'd4;
  localparam logic [NUM_W-1:0] SAT_X     = 27'd587529;  // 9 * 65281
  localparam logic [OUT_W-1:0] SAT_Q     = 16'd65280;

  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] sharp_pixel;
    logic             frame_last;
  } out_item_t;

  // One column of the 3x3 window, top to bottom.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // Neighborhood summary handed to the sharpening pipeline.
  typedef struct packed {
    logic [WIN_SUM_W-1:0] sum;
    logic [PIX_W-1:0]     center;
    logic                 last;
  } win_t;

  function automatic logic [COL_SUM_W-1:0] col_sum(col_t c);
    col_sum = COL_SUM_W'(c.top) + COL_SUM_W'(c.mid) + COL_SUM_W'(c.bot);
  endfunction

endpackage

[rtl/core/usm_line_store.sv]
// Line store memory holding the upper and middle rows, one word per column.
module usm_line_store import usm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  output logic [2*PIX_W-1:0]           rd_data_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  logic [2*PIX_W-1:0]           wr_data_i
);

  logic [2*PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/usm_cell.sv]
// One window column cell: holds a pixel column and gives its sum.
module usm_cell import usm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 clear_i,
  input  col_t                 col_i,
  output col_t                 col_o,
  output logic [COL_SUM_W-1:0] sum_o
);

  col_t col_d, col_q;

  always_comb begin
    col_d = col_q;
    if (en_i) begin
      col_d = clear_i ? '0 : col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;
  assign sum_o = col_sum(col_q);

endmodule

[rtl/core/usm_sharpen.sv]
// Sharpening pipeline: gain product, rounding divide by nine, clipping.
module usm_sharpen import usm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [GAIN_W-1:0] gain_i,
  input  logic              win_valid_i,
  input  win_t              win_i,
  output logic              win_ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  logic a_v_q, b_v_q, c_v_q, o_v_q;
  logic a_rdy, b_rdy, c_rdy, o_rdy;

  win_t                     a_q;
  logic signed [PROD_W-1:0] b_prod_q;
  logic [PIX_W-1:0]         b_pix_q;
  logic                     b_last_q;
  logic [QX_W-1:0]          c_x_q;
  logic                     c_zero_q, c_sat_q, c_last_q;
  out_item_t                o_q;

  logic [WIN_SUM_W-1:0]     p9;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] gain_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [NUM_W-1:0]  num, x;
  logic [2*QX_W-1:0]        qm;

  assign o_rdy = !o_v_q || !out_stall_i;
  assign c_rdy = !c_v_q || o_rdy;
  assign b_rdy = !b_v_q || c_rdy;
  assign a_rdy = !a_v_q || b_rdy;
  assign win_ready_o = a_rdy;

  // Stage a to b: gain times (9p - S).
  assign p9     = (WIN_SUM_W'(a_q.center) << 3) + WIN_SUM_W'(a_q.center);
  assign diff   = $signed({1'b0, p9}) - $signed({1'b0, a_q.sum});
  assign gain_s = $signed({1'b0, gain_i});
  assign prod   = PROD_W'(gain_s) * PROD_W'(diff);

  // Stage b to c: add the unit term and the rounding offset.
  assign num = $signed(ONE_Q * NUM_W'(b_pix_q)) + NUM_W'(b_prod_q);
  assign x   = num + $signed(ROUND_OFS);

  // Stage c to output: reciprocal multiply gives floor(x / 9).
  assign qm = (2*QX_W)'(c_x_q) * (2*QX_W)'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= win_valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (o_rdy) o_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_q <= win_i;
    end
    if (b_rdy) begin
      b_prod_q <= prod;
      b_pix_q  <= a_q.center;
      b_last_q <= a_q.last;
    end
    if (c_rdy) begin
      c_x_q    <= x[QX_W-1:0];
      c_zero_q <= (num <= 0);
      c_sat_q  <= (x >= $signed(SAT_X));
      c_last_q <= b_last_q;
    end
    if (o_rdy) begin
      if (c_zero_q) begin
        o_q.sharp_pixel <= '0;
      end else if (c_sat_q) begin
        o_q.sharp_pixel <= SAT_Q;
      end else begin
        o_q.sharp_pixel <= qm[RECIP_SH +: OUT_W];
      end
      o_q.frame_last <= c_last_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_q;

endmodule

[rtl/core/unsharp_mask_3x3_box_core.sv]
// Path: a result reaches the output register through the stage 1 register and the sharpen registers a, b and c.
// In stream terms each result trails its pixel by one row plus one pixel.
// Throughput: one pixel per cycle while the output is not stalled, set by the one read and one write of the line store.
// Reset (asynchronous, active low) clears the counters, the window and the pipeline and loads
// the register defaults; the line store is not cleared, rows above the top are masked to zero.
module unsharp_mask_3x3_box_core import usm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = (WW > WIDTH_W) ? WW : WIDTH_W;

  // Configuration registers.
  logic [GAIN_W-1:0]   gain_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  reg_idx_e            reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN:   prdata = CFG_DATA_W'(gain_q);
      REG_WIDTH:  prdata = CFG_DATA_W'(width_q);
      REG_HEIGHT: prdata = CFG_DATA_W'(height_q);
      default:    prdata = '0;
    endcase
  end

  // Effective frame size.
  logic [CW-1:0]    w_ext, w_eff;
  logic [ROW_W-1:0] h_ext, h_eff, h_p1;

  assign w_ext = CW'(width_q);
  assign h_ext = ROW_W'(height_q);
  assign h_p1  = h_eff + ROW_W'(1);

  always_comb begin
    if (w_ext < CW'(MIN_DIM)) begin
      w_eff = CW'(MIN_DIM);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (h_ext < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : h_ext;
  end

  // Input position tracking and handshake.
  logic [AW-1:0]    col_d, col_q;
  logic [ROW_W-1:0] row_d, row_q;
  logic             accept, s1_ready, s1_go, sh_ready;
  logic             wrap, c0, produced, last;
  logic [AW-1:0]    c;
  logic [CW-1:0]    c_plus;
  logic [ROW_W-1:0] r0, r;
  logic [PIX_W-1:0] v;

  assign accept     = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  assign wrap     = CW'(col_q) >= w_eff;
  assign c        = wrap ? '0 : col_q;
  assign r0       = wrap ? row_q + ROW_W'(1) : row_q;
  assign r        = (r0 > h_p1) ? h_p1 : r0;
  assign c0       = (c == '0);
  assign produced = c0 ? (r >= ROW_W'(2)) : (r >= ROW_W'(1));
  assign last     = c0 && (r == h_p1);
  assign c_plus   = CW'(c) + CW'(1);
  assign v        = (!in_data_i.mode && (r < h_eff)) ? in_data_i.pixel_value : '0;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (c_plus >= w_eff) begin
        col_d = '0;
        row_d = r + ROW_W'(1);
      end else begin
        col_d = c_plus[AW-1:0];
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: line store data arrives, window cells shift.
  logic             s1_v_q;
  logic [AW-1:0]    s1_c_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_mtop_q, s1_mmid_q, s1_c0_q, s1_prod_q, s1_last_q;

  assign s1_go    = s1_v_q && (!s1_prod_q || sh_ready);
  assign s1_ready = !s1_v_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_c_q    <= c;
      s1_pix_q  <= v;
      s1_mtop_q <= (r >= ROW_W'(2));
      s1_mmid_q <= (r >= ROW_W'(1));
      s1_c0_q   <= c0;
      s1_prod_q <= produced;
      s1_last_q <= last;
    end
  end

  logic [2*PIX_W-1:0] rd_data;
  col_t               new_col, cell_a_col, cell_b_col;
  logic [COL_SUM_W-1:0] cell_a_sum, cell_b_sum, new_sum;
  win_t               win;

  usm_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_c_q),
    .wr_data_i ({new_col.mid, new_col.bot})
  );

  assign new_col.top = s1_mtop_q ? rd_data[2*PIX_W-1:PIX_W] : '0;
  assign new_col.mid = s1_mmid_q ? rd_data[PIX_W-1:0] : '0;
  assign new_col.bot = s1_pix_q;
  assign new_sum     = col_sum(new_col);

  // Cell b holds the newest column and hands it to cell a. A row start empties cell a.
  usm_cell u_cell_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_go),
    .clear_i (1'b0),
    .col_i   (new_col),
    .col_o   (cell_b_col),
    .sum_o   (cell_b_sum)
  );

  usm_cell u_cell_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_go),
    .clear_i (s1_c0_q),
    .col_i   (cell_b_col),
    .col_o   (cell_a_col),
    .sum_o   (cell_a_sum)
  );

  // At a row start the right edge of the previous row is finished with a zero column.
  assign win.sum = WIN_SUM_W'(cell_a_sum) + WIN_SUM_W'(cell_b_sum)
                 + (s1_c0_q ? '0 : WIN_SUM_W'(new_sum));
  assign win.center = cell_b_col.mid;
  assign win.last   = s1_last_q;

  usm_sharpen u_sharpen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (gain_q),
    .win_valid_i (s1_v_q && s1_prod_q),
    .win_i       (win),
    .win_ready_o (sh_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  logic unused_top;
  assign unused_top = ^cell_a_col;

endmodule
